// ===== hdl/assert_macros.svh =====
// assertion macros shared by the checker files
// every macro samples on clk_i and is quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold on the same edge as the antecedent
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// consequent must hold on the edge after the antecedent completes
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== hdl/lfng_pkg.sv =====
`default_nettype none
package lfng_pkg;

  // register map, one 32-bit word each
  typedef enum logic [1:0] {
    RegInvRate  = 2'd0,
    RegInterp   = 2'd1,
    RegStartFwd = 2'd2,
    RegSeed     = 2'd3
  } reg_idx_e;

  localparam logic [31:0] LcgMul      = 32'd435898247;
  localparam logic [31:0] LcgAdd      = 32'd382842987;
  localparam logic [31:0] NoiseOffset = 32'h4000_0000;

  localparam logic [31:0] InvRateReset = 32'd89478;
  localparam logic [31:0] SeedReset    = 32'd404933;

  // 1.0 in the q2.32 phase format
  localparam logic signed [34:0] PhaseOne = 35'sd4294967296;

  // q1.30 sample limits
  localparam logic signed [34:0] SampleMax = 35'sd1073741823;
  localparam logic signed [34:0] SampleMin = -35'sd1073741824;

  // low 31 bits of the word, re-centred around zero
  function automatic logic signed [30:0] noise_of(input logic [31:0] w);
    logic signed [31:0] t;
    t = $signed({1'b0, w[30:0]}) - $signed(NoiseOffset);
    return t[30:0];
  endfunction

  localparam logic [63:0] RngResetWide =
    64'(SeedReset) * 64'(LcgMul) + 64'(LcgAdd);
  localparam logic [31:0] RngReset = RngResetWide[31:0];
  localparam logic signed [30:0] CurReset = noise_of(SeedReset);

endpackage
`default_nettype wire

// ===== hdl/lfng_step.sv =====
`default_nettype none
// input register and phase increment: frequency times reciprocal rate
module lfng_step (
  input  logic                clk_i,
  input  logic                en1_i,
  input  logic                en2_i,
  input  logic signed [27:0]  frequency_i,
  input  logic [31:0]         inv_rate_i,
  output logic signed [33:0]  step_o,
  output logic                fwd_o
);

  localparam logic signed [52:0] StepHi = 53'sd4294967296;
  localparam logic signed [52:0] StepLo = -53'sd4294967296;

  logic signed [27:0] freq_q;
  logic signed [60:0] prod;
  logic signed [52:0] shifted;
  logic signed [52:0] clipped;
  logic signed [33:0] step_q;
  logic               fwd_q;

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      freq_q <= frequency_i;
    end
  end

  // q20.8 times q0.32, drop 8 bits with floor, clip to +-1.0
  always_comb begin
    prod    = $signed(freq_q) * $signed({1'b0, inv_rate_i});
    shifted = prod[60:8];
    if (shifted > StepHi) begin
      clipped = StepHi;
    end else if (shifted < StepLo) begin
      clipped = StepLo;
    end else begin
      clipped = shifted;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      step_q <= clipped[33:0];
      fwd_q  <= ~freq_q[27];
    end
  end

  assign step_o = step_q;
  assign fwd_o  = fwd_q;

endmodule
`default_nettype wire

// ===== hdl/lfng_state.sv =====
`default_nettype none
// phase accumulator, value pair and generator; prepares interpolation operands
module lfng_state (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                en3_i,
  input  logic signed [33:0]  step_i,
  input  logic                fwd_i,
  input  logic                seed_load_i,
  input  logic [31:0]         seed_i,
  input  logic                start_fwd_i,
  output logic signed [31:0]  diff_o,
  output logic signed [33:0]  weight_o,
  output logic signed [30:0]  prev_o,
  output logic signed [30:0]  cur_o
);

  localparam logic signed [35:0] One36    = 36'sd4294967296;
  localparam logic signed [35:0] PhaseHi  = 36'sd17179869183;
  localparam logic signed [35:0] PhaseLo  = -36'sd17179869184;

  logic signed [34:0] phase_q, phase_d;
  logic signed [30:0] cur_q, cur_d;
  logic signed [30:0] prev_q, prev_d;
  logic [31:0]        rng_q, rng_d;

  logic               wrap;
  logic signed [34:0] phase_w;
  logic signed [35:0] ph_ext;
  logic signed [35:0] sum;
  logic signed [35:0] sum_c;
  logic signed [35:0] w_raw;
  logic signed [35:0] w_c;
  logic signed [30:0] cur_w;
  logic signed [30:0] prev_w;
  logic signed [31:0] diff;
  logic [31:0]        mul_in;
  logic [31:0]        lcg;

  // one generator multiplier, shared by seed load and wrap
  assign mul_in = seed_load_i ? seed_i : rng_q;
  assign lcg    = 32'(mul_in * lfng_pkg::LcgMul) + lfng_pkg::LcgAdd;

  always_comb begin
    wrap = fwd_i ? (phase_q >= lfng_pkg::PhaseOne) : (phase_q <= 35'sd0);
    if (!wrap) begin
      phase_w = phase_q;
    end else if (fwd_i) begin
      phase_w = phase_q - lfng_pkg::PhaseOne;
    end else begin
      phase_w = phase_q + lfng_pkg::PhaseOne;
    end
    cur_w  = wrap ? lfng_pkg::noise_of(rng_q) : cur_q;
    prev_w = wrap ? cur_q : prev_q;
    ph_ext = {phase_w[34], phase_w};

    sum = ph_ext + {{2{step_i[33]}}, step_i};
    if (sum > PhaseHi) begin
      sum_c = PhaseHi;
    end else if (sum < PhaseLo) begin
      sum_c = PhaseLo;
    end else begin
      sum_c = sum;
    end

    // weight runs from the previous value towards the current one
    w_raw = fwd_i ? ph_ext : (One36 - ph_ext);
    if (w_raw > One36) begin
      w_c = One36;
    end else if (w_raw < -One36) begin
      w_c = -One36;
    end else begin
      w_c = w_raw;
    end

    diff = {cur_w[30], cur_w} - {prev_w[30], prev_w};
  end

  always_comb begin
    phase_d = phase_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    rng_d   = rng_q;
    if (seed_load_i) begin
      phase_d = start_fwd_i ? lfng_pkg::PhaseOne : 35'sd0;
      cur_d   = lfng_pkg::noise_of(seed_i);
      rng_d   = lcg;
    end else if (adv_i) begin
      phase_d = sum_c[34:0];
      cur_d   = cur_w;
      prev_d  = prev_w;
      rng_d   = wrap ? lcg : rng_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lfng_pkg::PhaseOne;
      cur_q   <= lfng_pkg::CurReset;
      prev_q  <= 31'sd0;
      rng_q   <= lfng_pkg::RngReset;
    end else begin
      phase_q <= phase_d;
      cur_q   <= cur_d;
      prev_q  <= prev_d;
      rng_q   <= rng_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3_i) begin
      diff_o   <= diff;
      weight_o <= w_c[33:0];
      prev_o   <= prev_w;
      cur_o    <= cur_w;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lfng_interp.sv =====
`default_nettype none
// interpolation product, final add with saturation, output register
module lfng_interp (
  input  logic                clk_i,
  input  logic                en4_i,
  input  logic                eno_i,
  input  logic                interp_i,
  input  logic signed [31:0]  diff_i,
  input  logic signed [33:0]  weight_i,
  input  logic signed [30:0]  prev_i,
  input  logic signed [30:0]  cur_i,
  output logic signed [30:0]  sample_o
);

  logic signed [65:0] prod_d, prod_q;
  logic signed [30:0] prev_q, cur_q;
  logic signed [34:0] y;
  logic signed [34:0] y_c;

  assign prod_d = $signed(diff_i) * $signed(weight_i);

  always_ff @(posedge clk_i) begin
    if (en4_i) begin
      prod_q <= prod_d;
      prev_q <= prev_i;
      cur_q  <= cur_i;
    end
  end

  // drop 32 fraction bits with floor, then saturate to q1.30
  always_comb begin
    y = {{4{prev_q[30]}}, prev_q} + {prod_q[65], prod_q[65:32]};
    if (y > lfng_pkg::SampleMax) begin
      y_c = lfng_pkg::SampleMax;
    end else if (y < lfng_pkg::SampleMin) begin
      y_c = lfng_pkg::SampleMin;
    end else begin
      y_c = y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eno_i) begin
      sample_o <= interp_i ? y_c[30:0] : cur_q;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/low_freq_noise_generator_core.sv =====
// low-frequency noise source, stepped or linearly interpolated
// input channel: one signed q20.8 frequency beat per audio sample on
//   frequency_i, qualified by in_valid_i and held off by in_stall_o
// output channel: one signed q1.30 noise beat on sample_o per input beat,
//   qualified by out_valid_o and held off by out_stall_i
// config: apb-style slave, registers at byte addresses 0 (reciprocal rate),
//   4 (interpolate), 8 (start forward), 12 (seed); pready is tied high
// a beat taken at an edge passes the five register stages (input, step, state,
//   product, output) on its way to sample_o
// throughput: one beat per cycle while out_stall_i is low; the phase/value/generator
//   state loops back through its own registers, so nothing waits on a previous beat
// stalls: every stage moves on as soon as the one after it is free, so
//   bubbles close up while the output is held; once all five stages are
//   full the input is held off in the same cycle as the output
// reset: reciprocal rate 48 kHz, hold mode, forward start, default seed;
//   phase, current value and generator load as after a seed write and the
//   previous value clears
// a seed write reloads generator, current value and phase at once
`default_nettype none
module low_freq_noise_generator_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [27:0]  frequency_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [30:0]  sample_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // configuration registers
  logic [31:0] inv_rate_q;
  logic        interp_q;
  logic        start_fwd_q;
  logic [31:0] seed_q;

  lfng_pkg::reg_idx_e cfg_idx;
  logic               cfg_wr;
  logic               seed_load;

  // per-stage valid flags and load enables
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic en1, en2, en3, en4, eno;

  logic signed [33:0] step;
  logic               fwd;
  logic signed [31:0] diff;
  logic signed [33:0] weight;
  logic signed [30:0] prev_v;
  logic signed [30:0] cur_v;

  assign pready    = 1'b1;
  assign cfg_idx   = lfng_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr    = psel & penable & pwrite;
  assign seed_load = cfg_wr && (cfg_idx == lfng_pkg::RegSeed);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_rate_q  <= lfng_pkg::InvRateReset;
      interp_q    <= 1'b0;
      start_fwd_q <= 1'b1;
      seed_q      <= lfng_pkg::SeedReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        lfng_pkg::RegInvRate:  inv_rate_q  <= pwdata;
        lfng_pkg::RegInterp:   interp_q    <= pwdata[0];
        lfng_pkg::RegStartFwd: start_fwd_q <= pwdata[0];
        lfng_pkg::RegSeed:     seed_q      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      lfng_pkg::RegInvRate:  prdata = inv_rate_q;
      lfng_pkg::RegInterp:   prdata = {31'd0, interp_q};
      lfng_pkg::RegStartFwd: prdata = {31'd0, start_fwd_q};
      lfng_pkg::RegSeed:     prdata = seed_q;
      default:               prdata = 32'd0;
    endcase
  end

  // a stage loads when it is empty or its contents move on this edge
  assign eno = ~vo_q | ~out_stall_i;
  assign en4 = ~v4_q | eno;
  assign en3 = ~v3_q | en4;
  assign en2 = ~v2_q | en3;
  assign en1 = ~v1_q | en2;

  assign in_stall_o  = ~en1;
  assign out_valid_o = vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (eno) vo_q <= v4_q;
    end
  end

  lfng_step u_step (
    .clk_i       (clk_i),
    .en1_i       (en1),
    .en2_i       (en2),
    .frequency_i (frequency_i),
    .inv_rate_i  (inv_rate_q),
    .step_o      (step),
    .fwd_o       (fwd)
  );

  // state advances once per beat as it leaves the step stage; a seed write in the same cycle takes priority
  lfng_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (v2_q & en3),
    .en3_i       (en3),
    .step_i      (step),
    .fwd_i       (fwd),
    .seed_load_i (seed_load),
    .seed_i      (pwdata),
    .start_fwd_i (start_fwd_q),
    .diff_o      (diff),
    .weight_o    (weight),
    .prev_o      (prev_v),
    .cur_o       (cur_v)
  );

  lfng_interp u_interp (
    .clk_i    (clk_i),
    .en4_i    (en4),
    .eno_i    (eno),
    .interp_i (interp_q),
    .diff_i   (diff),
    .weight_i (weight),
    .prev_i   (prev_v),
    .cur_i    (cur_v),
    .sample_o (sample_o)
  );

endmodule
`default_nettype wire

// ===== hdl/lfng_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
// port-level checks on the noise generator
module lfng_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic signed [30:0]  sample_o
);

  // a held result keeps its beat
  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(sample_o))

  // a free output leaves the whole pipe free
  `ASSERT_NOW(a_free_flow, !out_stall_i, !in_stall_o)

  // with no back-pressure a beat that went in comes out with out_valid_o
  `ASSERT_NEXT(a_latency, in_valid_i && !in_stall_o ##1 !out_stall_i [*4], out_valid_o)

endmodule

bind low_freq_noise_generator_core lfng_checker u_lfng_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  // q2.32 unity and the phase bound, q1.30 sample limits
  localparam longint Unity    = 64'sd4294967296;
  localparam longint PhaseTop = 64'sd17179869183;
  localparam longint PhaseBot = -64'sd17179869184;
  localparam longint SmpTop   = 64'sd1073741823;
  localparam longint SmpBot   = -64'sd1073741824;
  localparam int     IdleLimit = 2000;

  // clock, reset and every block input start at a known value
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic signed [27:0] frequency_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [30:0] sample_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [3:0]         paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  low_freq_noise_generator_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .frequency_i (frequency_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sample_o    (sample_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // frequency beats waiting to go out, noise samples waiting to come back
  logic signed [27:0] pending_freqs[$];
  logic signed [30:0] expected_samples[$];

  int  fail_cnt   = 0;
  bit  quiet      = 1'b0;   // no idling on either side while set
  bit  beat_busy  = 1'b0;   // a beat is on the input channel, not yet taken
  int  send_gap   = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;

  // mirror of the register file
  logic [31:0] inv_rate_m;
  logic        interp_m;
  logic        start_fwd_m;
  logic [31:0] seed_m;

  // mirror of the generator state
  longint      phase_m;
  longint      cur_m;
  longint      prev_m;
  logic [31:0] lcg_m;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // low 31 bits of a generator word, re-centred on zero
  function automatic longint word_to_noise(input logic [31:0] w);
    longint r;
    r = w[30:0];
    return r - longint'(32'h4000_0000);
  endfunction

  // seed write (and reset): generator, current value and phase reload,
  // the previous value stays as it was
  function automatic void reload_generator();
    cur_m   = word_to_noise(seed_m);
    lcg_m   = seed_m * lfng_pkg::LcgMul + lfng_pkg::LcgAdd;
    phase_m = start_fwd_m ? Unity : 64'sd0;
  endfunction

  // one frequency beat in, one noise sample out, state advanced
  function automatic logic signed [30:0] predict_sample(input logic signed [27:0] freq);
    longint f;
    longint rate;
    longint incr;
    longint weight;
    longint y;
    bit     fwd;
    f    = freq;
    rate = inv_rate_m;
    fwd  = (f >= 0);
    // arithmetic shifts on signed 64-bit give the floor rounding
    incr = clip((f * rate) >>> 8, -Unity, Unity);
    if (fwd ? (phase_m >= Unity) : (phase_m <= 0)) begin
      phase_m = phase_m + (fwd ? -Unity : Unity);
      prev_m  = cur_m;
      cur_m   = word_to_noise(lcg_m);
      lcg_m   = lcg_m * lfng_pkg::LcgMul + lfng_pkg::LcgAdd;
    end
    if (interp_m) begin
      // weight leaves [0,1] after a direction change and extrapolates
      weight = clip(fwd ? phase_m : Unity - phase_m, -Unity, Unity);
      y = clip(prev_m + (((cur_m - prev_m) * weight) >>> 32), SmpBot, SmpTop);
    end else begin
      y = cur_m;
    end
    phase_m = clip(phase_m + incr, PhaseBot, PhaseTop);
    return y[30:0];
  endfunction

  // gap lengths: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // input driver: a beat stays up, unchanged, until it is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      beat_busy = 1'b0;
      send_gap  = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_samples.push_back(predict_sample(frequency_i));
        beat_busy = 1'b0;
      end
      if (!beat_busy) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_freqs.size() != 0) begin
          frequency_i <= pending_freqs.pop_front();
          beat_busy = 1'b1;
          send_gap  = quiet ? 0 : pick_gap();
        end
      end
      // one assignment per edge, so back-to-back beats keep valid high
      in_valid_i <= beat_busy;
    end
  end

  // output monitor and random back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          if (fail_cnt < 10) $display("unexpected sample beat: %0d", sample_o);
          fail_cnt++;
        end else if (sample_o !== expected_samples[0]) begin
          if (fail_cnt < 10)
            $display("sample mismatch: expected %0d, got %0d",
                     expected_samples[0], sample_o);
          fail_cnt++;
          void'(expected_samples.pop_front());
        end else begin
          void'(expected_samples.pop_front());
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = quiet ? 0 : pick_gap();
      end
    end
  end

  // watchdog on cycles in which no beat and no register write goes through
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
                 (psel && penable && pwrite)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // apb write: setup cycle, then access cycle; pready is always high
  task automatic write_reg(input lfng_pkg::reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      lfng_pkg::RegInvRate:  inv_rate_m = val;
      lfng_pkg::RegInterp:   interp_m = val[0];
      lfng_pkg::RegStartFwd: start_fwd_m = val[0];
      lfng_pkg::RegSeed: begin
        seed_m = val;
        reload_generator();
      end
      default: ;
    endcase
  endtask

  // every beat sent and every sample back: the block is idle
  task automatic wait_drained();
    while (pending_freqs.size() != 0 || beat_busy || expected_samples.size() != 0)
      @(posedge clk_i);
  endtask

  // runs of one direction with random size, plus some full-range noise
  task automatic add_random_items(input int n);
    int cnt;
    int run_len;
    int cls;
    int mag;
    bit neg;
    cnt = 0;
    while (cnt < n) begin
      run_len = $urandom_range(1, 24);
      neg     = 1'($urandom_range(0, 1));
      cls     = $urandom_range(0, 9);
      for (int k = 0; k < run_len && cnt < n; k++) begin
        case (cls)
          0, 1:    mag = -1;
          2, 3, 4: mag = $urandom_range(0, 134217727);
          5, 6, 7: mag = $urandom_range(0, 4194304);
          8:       mag = $urandom_range(0, 4095);
          default: mag = 0;
        endcase
        if (mag < 0) pending_freqs.push_back(28'($urandom()));
        else pending_freqs.push_back(28'(neg ? -mag - 1 : mag));
        cnt++;
      end
    end
  endtask

  initial begin
    logic [31:0] rate;
    // state after reset
    inv_rate_m  = lfng_pkg::InvRateReset;
    interp_m    = 1'b0;
    start_fwd_m = 1'b1;
    seed_m      = lfng_pkg::SeedReset;
    prev_m      = 0;
    reload_generator();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, hold mode: clipped steps both ways, zero and +/-1
    quiet = 1'b1;
    pending_freqs = '{28'sd134217727, 28'sd134217727, -28'sd134217728, -28'sd134217728,
                      28'sd0, 28'sd1, -28'sd1, 28'sd0, 28'sd134217727};
    wait_drained();

    // interpolation, largest rate, backward start, all-ones seed;
    // direction changes push the weight out of range
    quiet = 1'b0;
    write_reg(lfng_pkg::RegInterp, 32'h1);
    write_reg(lfng_pkg::RegInvRate, 32'hffff_ffff);
    write_reg(lfng_pkg::RegStartFwd, 32'h0);
    write_reg(lfng_pkg::RegSeed, 32'hffff_ffff);
    pending_freqs = '{28'sd1000, 28'sd1000, 28'sd5000000, -28'sd5000000, -28'sd1,
                      28'sd134217727, -28'sd134217728, 28'sd100, -28'sd100};
    wait_drained();

    // zero reciprocal freezes the phase, zero seed
    write_reg(lfng_pkg::RegInvRate, 32'h0);
    write_reg(lfng_pkg::RegSeed, 32'h0);
    // start direction only latches at the next seed write
    write_reg(lfng_pkg::RegStartFwd, 32'h1);
    pending_freqs = '{28'sd134217727, -28'sd134217728, 28'sd77, 28'sd0};
    wait_drained();

    // random settings, one drained phase each
    for (int p = 0; p < 12; p++) begin
      case ($urandom_range(0, 7))
        0:       rate = 32'd1;
        1:       rate = 32'hffff_ffff;
        2:       rate = lfng_pkg::InvRateReset;
        3, 4:    rate = $urandom();
        5, 6:    rate = $urandom_range(1, 1048576);
        default: rate = 32'd0;
      endcase
      write_reg(lfng_pkg::RegInvRate, rate);
      write_reg(lfng_pkg::RegInterp,
                {$urandom_range(0, 1) ? $urandom() : 32'h0} ^ $urandom_range(0, 1));
      write_reg(lfng_pkg::RegStartFwd, $urandom());
      if ($urandom_range(0, 4) != 0)
        write_reg(lfng_pkg::RegSeed,
                  (p == 0) ? 32'h0 : ((p == 1) ? 32'hffff_ffff : $urandom()));
      quiet = ($urandom_range(0, 3) == 0);
      add_random_items(152);
      wait_drained();
    end

    // allow a stray late beat to show up
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
